>>> rtl/core/pfla_pkg.sv
// ----------------------------------------------------------------------------
// pfla_pkg
// Shared constants, codes and control types of the page free-list allocator.
// ----------------------------------------------------------------------------
package pfla_pkg;

    // Address width of the pool, fixed by the width of the address fields.
    localparam int ADDR_BITS     = 32;
    localparam int DEF_PAGE_BITS = 12;
    localparam int DEF_MAX_PAGES = 1024;

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INIT  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_END   = 1'b1;

    // Source of the result that the controller retires.
    typedef enum logic [2:0] {
        RES_ZERO,
        RES_EMPTY,
        RES_ALLOC,
        RES_FREE,
        RES_PEND
    } res_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     alloc_rd;
        logic     alloc_pop;
        logic     free_op;
        logic     init_start;
        logic     init_cnt;
        logic     init_push;
        logic     finish;
        res_sel_t res_sel;
    } pfla_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic head_null;
        logic walk_more;
        logic out_free;
    } pfla_sts_t;

endpackage

>>> rtl/core/pfla_ram.sv
// ----------------------------------------------------------------------------
// pfla_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pfla_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/pfla_ctrl.sv
// ----------------------------------------------------------------------------
// pfla_ctrl
// Controller of the allocator: sequences allocate, free and initialize.
// ----------------------------------------------------------------------------
module pfla_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [pfla_pkg::MODE_W-1:0]   mode,
    input  pfla_pkg::pfla_sts_t           sts,
    output pfla_pkg::pfla_cmd_t           cmd
);
    import pfla_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_INIT_CNT,
        S_INIT_WALK,
        S_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.res_sel = RES_ZERO;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_ALLOC:
                        begin
                            if (sts.head_null)
                            begin
                                cmd.finish  = 1'b1;
                                cmd.res_sel = RES_EMPTY;
                                state_next  = sts.out_free ? S_IDLE : S_HOLD;
                            end
                            else
                            begin
                                cmd.alloc_rd = 1'b1;
                                state_next   = S_ALLOC;
                            end
                        end
                        MODE_FREE:
                        begin
                            cmd.free_op = 1'b1;
                            cmd.finish  = 1'b1;
                            cmd.res_sel = RES_FREE;
                            state_next  = sts.out_free ? S_IDLE : S_HOLD;
                        end
                        MODE_INIT:
                        begin
                            cmd.init_start = 1'b1;
                            state_next     = S_INIT_CNT;
                        end
                        default:
                        begin
                            cmd.finish  = 1'b1;
                            cmd.res_sel = RES_ZERO;
                            state_next  = sts.out_free ? S_IDLE : S_HOLD;
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                cmd.alloc_pop = 1'b1;
                cmd.finish    = 1'b1;
                cmd.res_sel   = RES_ALLOC;
                state_next    = sts.out_free ? S_IDLE : S_HOLD;
            end
            S_INIT_CNT:
            begin
                cmd.init_cnt = 1'b1;
                state_next   = S_INIT_WALK;
            end
            S_INIT_WALK:
            begin
                if (sts.walk_more)
                begin
                    cmd.init_push = 1'b1;
                end
                else
                begin
                    cmd.finish  = 1'b1;
                    cmd.res_sel = RES_ZERO;
                    state_next  = sts.out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD:
            begin
                // The finished result waits in the pending register.
                cmd.res_sel = RES_PEND;
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_alloc_retires: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ALLOC) |=> (state_reg == S_IDLE || state_reg == S_HOLD))
        else $error("allocate did not retire after the link read");

    a_hold_has_full_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_HOLD) |-> !$past(sts.out_free))
        else $error("result parked while the output register was free");

    a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.alloc_rd || cmd.free_op || cmd.init_start) |-> $past(state_reg) != S_HOLD
        || state_reg == S_IDLE)
        else $error("operation started outside the idle state");

endmodule

>>> rtl/core/pfla_datapath.sv
// ----------------------------------------------------------------------------
// pfla_datapath
// Datapath of the allocator: registers, list head, link memory and result.
// ----------------------------------------------------------------------------
module pfla_datapath #(
    parameter int PAGE_BITS = pfla_pkg::DEF_PAGE_BITS,
    parameter int MAX_PAGES = pfla_pkg::DEF_MAX_PAGES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pfla_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pfla_pkg::ADDR_BITS-1:0]   cfg_data,
    input  logic [pfla_pkg::ADDR_BITS-1:0]   page_address,
    input  pfla_pkg::pfla_cmd_t              cmd,
    output pfla_pkg::pfla_sts_t              sts,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [pfla_pkg::ADDR_BITS-1:0]   result_address,
    output logic [pfla_pkg::STATUS_W-1:0]    status
);
    import pfla_pkg::*;

    localparam int PNUM_W = ADDR_BITS - PAGE_BITS;
    localparam int IDX_W  = $clog2(MAX_PAGES + 1);
    localparam int AW     = $clog2(MAX_PAGES);
    localparam int CMP_W  = ADDR_BITS + 1;
    localparam int SPAN_W = CMP_W - PAGE_BITS;
    localparam logic [IDX_W-1:0] NULL_IDX  = IDX_W'(MAX_PAGES);
    localparam logic [CMP_W-1:0] PAGE_MASK = (CMP_W'(1) << PAGE_BITS) - CMP_W'(1);

    logic [ADDR_BITS-1:0] pool_start_reg, pool_start_next;
    logic [ADDR_BITS-1:0] pool_end_reg, pool_end_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [PNUM_W-1:0]    base_page_reg, base_page_next;
    logic [CMP_W-1:0]     rounded_reg, rounded_next;
    logic [SPAN_W-1:0]    span_reg, span_next;
    logic [IDX_W-1:0]     walk_idx_reg, walk_idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic [ADDR_BITS-1:0] out_addr_reg, out_addr_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [ADDR_BITS-1:0] pend_addr_reg, pend_addr_next;
    logic [STATUS_W-1:0]  pend_status_reg, pend_status_next;

    logic [CMP_W-1:0]     rounded_c;
    logic                 rounded_ok;
    logic [PNUM_W-1:0]    free_pnum;
    logic [PNUM_W-1:0]    free_off;
    logic                 free_ok;
    logic [IDX_W-1:0]     free_idx;
    logic                 out_free;
    logic [ADDR_BITS-1:0] res_addr;
    logic [STATUS_W-1:0]  res_status;
    logic [IDX_W-1:0]     link_rdata;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [IDX_W-1:0]     ram_wdata;
    logic [IDX_W-1:0]     push_idx;

    pfla_ram #(
        .DATA_W (IDX_W),
        .DEPTH  (MAX_PAGES)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.alloc_rd),
        .raddr (head_reg[AW-1:0]),
        .rdata (link_rdata)
    );

    // Start of the pool rounded up to a page; the top bit flags a wrap.
    assign rounded_c  = (CMP_W'(pool_start_reg) + PAGE_MASK) & ~PAGE_MASK;
    assign rounded_ok = !rounded_reg[ADDR_BITS] &&
                        (rounded_reg[ADDR_BITS-1:0] < pool_end_reg);

    assign free_pnum = page_address[ADDR_BITS-1:PAGE_BITS];
    assign free_off  = free_pnum - base_page_reg;
    assign free_idx  = IDX_W'(free_off);
    assign free_ok   = (page_address[PAGE_BITS-1:0] == '0) &&
                       (page_address >= pool_start_reg) &&
                       (page_address < pool_end_reg) &&
                       (free_pnum >= base_page_reg) &&
                       (CMP_W'(free_off) < CMP_W'(MAX_PAGES));

    assign out_free = !out_valid_reg || !result_stall;

    assign sts.head_null = (head_reg == NULL_IDX);
    assign sts.walk_more = (CMP_W'(walk_idx_reg) < CMP_W'(span_reg)) &&
                           (walk_idx_reg != NULL_IDX);
    assign sts.out_free  = out_free;

    // A push writes the old head as the link of the new head page.
    assign push_idx  = cmd.init_push ? walk_idx_reg : free_idx;
    assign ram_we    = cmd.init_push || (cmd.free_op && free_ok);
    assign ram_waddr = push_idx[AW-1:0];
    assign ram_wdata = head_reg;

    always_comb
    begin
        case (cmd.res_sel)
            RES_EMPTY:
            begin
                res_addr   = '0;
                res_status = STATUS_EMPTY;
            end
            RES_ALLOC:
            begin
                res_addr   = {PNUM_W'(base_page_reg + PNUM_W'(head_reg)),
                              PAGE_BITS'(0)};
                res_status = STATUS_OK;
            end
            RES_FREE:
            begin
                res_addr   = '0;
                res_status = free_ok ? STATUS_OK : STATUS_BAD;
            end
            RES_PEND:
            begin
                res_addr   = pend_addr_reg;
                res_status = pend_status_reg;
            end
            default:
            begin
                res_addr   = '0;
                res_status = STATUS_OK;
            end
        endcase
    end

    always_comb
    begin
        pool_start_next  = pool_start_reg;
        pool_end_next    = pool_end_reg;
        head_next        = head_reg;
        base_page_next   = base_page_reg;
        rounded_next     = rounded_reg;
        span_next        = span_reg;
        walk_idx_next    = walk_idx_reg;
        out_valid_next   = out_valid_reg;
        out_addr_next    = out_addr_reg;
        out_status_next  = out_status_reg;
        pend_addr_next   = pend_addr_reg;
        pend_status_next = pend_status_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POOL_START: pool_start_next = cfg_data;
                CFG_POOL_END:   pool_end_next   = cfg_data;
                default:        ;
            endcase
        end

        if (cmd.init_start)
        begin
            head_next      = NULL_IDX;
            rounded_next   = rounded_c;
            base_page_next = rounded_c[ADDR_BITS-1:PAGE_BITS];
            walk_idx_next  = '0;
        end

        if (cmd.init_cnt)
        begin
            span_next = rounded_ok ?
                SPAN_W'((CMP_W'(pool_end_reg) + PAGE_MASK - rounded_reg) >> PAGE_BITS) :
                '0;
        end

        if (cmd.init_push)
        begin
            head_next     = walk_idx_reg;
            walk_idx_next = walk_idx_reg + IDX_W'(1);
        end

        if (cmd.free_op && free_ok)
        begin
            head_next = free_idx;
        end

        if (cmd.alloc_pop)
        begin
            head_next = (link_rdata > NULL_IDX) ? NULL_IDX : link_rdata;
        end

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.finish)
        begin
            if (out_free)
            begin
                out_valid_next  = 1'b1;
                out_addr_next   = res_addr;
                out_status_next = res_status;
            end
            else
            begin
                pend_addr_next   = res_addr;
                pend_status_next = res_status;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_start_reg <= '0;
            pool_end_reg   <= '0;
            head_reg       <= NULL_IDX;
            base_page_reg  <= '0;
            walk_idx_reg   <= '0;
            span_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pool_start_reg <= pool_start_next;
            pool_end_reg   <= pool_end_next;
            head_reg       <= head_next;
            base_page_reg  <= base_page_next;
            walk_idx_reg   <= walk_idx_next;
            span_reg       <= span_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rounded_reg     <= rounded_next;
        out_addr_reg    <= out_addr_next;
        out_status_reg  <= out_status_next;
        pend_addr_reg   <= pend_addr_next;
        pend_status_reg <= pend_status_next;
    end

    assign result_valid   = out_valid_reg;
    assign result_address = out_addr_reg;
    assign status         = out_status_reg;

    a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= NULL_IDX)
        else $error("list head beyond the null index");

    a_init_clears_list: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.init_start |=> sts.head_null)
        else $error("list not empty after the start of initialization");

    a_push_not_null: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (push_idx != NULL_IDX))
        else $error("link write at the null index");

endmodule

>>> rtl/core/page_free_list_allocator.sv
// ----------------------------------------------------------------------------
// page_free_list_allocator
// Fixed-page allocator keeping free pages on a LIFO linked list in a link RAM.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Payload
//  item      in         item_valid/item_stall   mode, page_address
//  result    out        result_valid/result_stall result_address, status
//  cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// Free finishes in the idle state, allocate passes through S_ALLOC for the
// registered read of the link RAM, and initialize through S_INIT_CNT and
// S_INIT_WALK, writing one link per cycle through the single RAM write port.
// Reset empties the list and clears both pool registers; the link RAM is not
// cleared. A new item is taken while an earlier result waits in the output
// register; a result that finds the output still full parks in a pending
// register and the item channel stalls until it moves on.
module page_free_list_allocator #(
    parameter int PAGE_BITS = pfla_pkg::DEF_PAGE_BITS,
    parameter int MAX_PAGES = pfla_pkg::DEF_MAX_PAGES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  logic [pfla_pkg::MODE_W-1:0]      mode,
    input  logic [pfla_pkg::ADDR_BITS-1:0]   page_address,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [pfla_pkg::ADDR_BITS-1:0]   result_address,
    output logic [pfla_pkg::STATUS_W-1:0]    status,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pfla_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pfla_pkg::ADDR_BITS-1:0]   cfg_data
);
    import pfla_pkg::*;

    pfla_cmd_t cmd;
    pfla_sts_t sts;
    logic      cfg_we;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    pfla_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .mode       (mode),
        .sts        (sts),
        .cmd        (cmd)
    );

    pfla_datapath #(
        .PAGE_BITS (PAGE_BITS),
        .MAX_PAGES (MAX_PAGES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .page_address   (page_address),
        .cmd            (cmd),
        .sts            (sts),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result_address (result_address),
        .status         (status)
    );

endmodule
